### sv/tlrqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlrqs_pkg;

    localparam int NUM_PROCS = 64;
    localparam int IDX_W     = $clog2(NUM_PROCS);
    localparam int LINK_W    = IDX_W + 1;
    localparam int STEP_W    = $clog2(NUM_PROCS + 1);
    localparam int LIMIT_W   = 7;
    localparam int OP_W      = 2;
    localparam int CLASS_W   = 2;
    localparam int NUM_QUEUES = 3;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_PROCS);

    localparam logic [OP_W-1:0] OP_READY   = 2'd0;
    localparam logic [OP_W-1:0] OP_UNREADY = 2'd1;
    localparam logic [OP_W-1:0] OP_ROTATE  = 2'd2;
    localparam logic [OP_W-1:0] OP_PICK    = 2'd3;

    localparam logic [CLASS_W-1:0] Q_TASK   = 2'd0;
    localparam logic [CLASS_W-1:0] Q_SERVER = 2'd1;
    localparam logic [CLASS_W-1:0] Q_USER   = 2'd2;

    localparam logic [1:0] REG_TASK_LIMIT   = 2'd0;
    localparam logic [1:0] REG_SERVER_LIMIT = 2'd1;
    localparam logic [1:0] REG_IDLE_INDEX   = 2'd2;

    localparam logic [LIMIT_W-1:0] TASK_LIMIT_RST   = 7'd8;
    localparam logic [LIMIT_W-1:0] SERVER_LIMIT_RST = 7'd16;
    localparam logic [5:0]         IDLE_INDEX_RST   = 6'd0;

    typedef struct packed {
        logic [LIMIT_W-1:0] task_limit;
        logic [LIMIT_W-1:0] server_limit;
        logic [5:0]         idle_index;
    } cfg_t;

    typedef struct packed {
        logic       done;
        logic       found;
        logic [5:0] current;
        logic [5:0] billed;
    } res_t;

endpackage

`default_nettype wire

### sv/three_level_ready_queue_scheduler_top.sv
// channel   signals                                   transfer when
// -------   ---------------------------------------   -----------------------------
// command   start, operation, proc_index, busy        start && !busy at clk rise
// result    done, current_proc, billed_proc,          done high, one cycle
//           was_found
// config    wr_en, wr_index, wr_data                  wr_en high at clk rise
//
// unready walks the queue one link per cycle through the link memory read port,
// so its time from transfer to result grows with the position in the queue.
// a new command may be given in the cycle done is high.
// reset empties all queues and sets current and billed process to process 0;
// the link memory is not cleared. results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module three_level_ready_queue_scheduler_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [tlrqs_pkg::OP_W-1:0]        operation,
    input  wire logic [5:0]                        proc_index,
    output logic                                   done,
    output logic [5:0]                             current_proc,
    output logic [5:0]                             billed_proc,
    output logic                                   was_found,
    input  wire logic                              wr_en,
    input  wire logic [1:0]                        wr_index,
    input  wire logic [tlrqs_pkg::LIMIT_W-1:0]     wr_data
);

    tlrqs_pkg::cfg_t                   cfg_reg;
    tlrqs_pkg::res_t                   res;
    logic [tlrqs_pkg::CLASS_W-1:0]     proc_class;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.task_limit   <= tlrqs_pkg::TASK_LIMIT_RST;
            cfg_reg.server_limit <= tlrqs_pkg::SERVER_LIMIT_RST;
            cfg_reg.idle_index   <= tlrqs_pkg::IDLE_INDEX_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                tlrqs_pkg::REG_TASK_LIMIT:
                begin
                    cfg_reg.task_limit <= wr_data;
                end
                tlrqs_pkg::REG_SERVER_LIMIT:
                begin
                    cfg_reg.server_limit <= wr_data;
                end
                tlrqs_pkg::REG_IDLE_INDEX:
                begin
                    cfg_reg.idle_index <= wr_data[5:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    tlrqs_class u_class
    (
        .proc_index (proc_index),
        .cfg        (cfg_reg),
        .proc_class (proc_class)
    );

    tlrqs_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .operation  (operation),
        .proc_index (proc_index),
        .proc_class (proc_class),
        .cfg        (cfg_reg),
        .busy       (busy),
        .res        (res)
    );

    assign done         = res.done;
    assign current_proc = res.current;
    assign billed_proc  = res.billed;
    assign was_found    = res.done & res.found;

endmodule

`default_nettype wire

### sv/tlrqs_class.sv
`timescale 1ns / 1ps
`default_nettype none

module tlrqs_class
(
    input  wire logic [5:0]                     proc_index,
    input  wire tlrqs_pkg::cfg_t                cfg,
    output logic [tlrqs_pkg::CLASS_W-1:0]       proc_class
);

    logic [tlrqs_pkg::LIMIT_W-1:0] idx_ext;

    assign idx_ext = {1'b0, proc_index};

    // task test wins when the limits cross
    always_comb
    begin
        if (idx_ext < cfg.task_limit)
        begin
            proc_class = tlrqs_pkg::Q_TASK;
        end
        else if (idx_ext < cfg.server_limit)
        begin
            proc_class = tlrqs_pkg::Q_SERVER;
        end
        else
        begin
            proc_class = tlrqs_pkg::Q_USER;
        end
    end

endmodule

`default_nettype wire

### sv/tlrqs_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module tlrqs_seq
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [tlrqs_pkg::OP_W-1:0]     operation,
    input  wire logic [5:0]                     proc_index,
    input  wire logic [tlrqs_pkg::CLASS_W-1:0]  proc_class,
    input  wire tlrqs_pkg::cfg_t                cfg,
    output logic                                busy,
    output tlrqs_pkg::res_t                     res
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DISPATCH  = 4'd1;
    localparam logic [3:0] ST_RDY_NIL   = 4'd2;
    localparam logic [3:0] ST_UR_HEAD   = 4'd3;
    localparam logic [3:0] ST_UR_WALK   = 4'd4;
    localparam logic [3:0] ST_UR_UNLINK = 4'd5;
    localparam logic [3:0] ST_RO_CHK    = 4'd6;
    localparam logic [3:0] ST_RO_FIX    = 4'd7;
    localparam logic [3:0] ST_HUNT      = 4'd8;

    localparam int IW = tlrqs_pkg::IDX_W;
    localparam int LW = tlrqs_pkg::LINK_W;
    localparam int SW = tlrqs_pkg::STEP_W;
    localparam int NQ = tlrqs_pkg::NUM_QUEUES;

    logic [3:0]                        state_reg, state_next;
    logic [tlrqs_pkg::OP_W-1:0]        op_reg, op_next;
    logic [IW-1:0]                     p_reg, p_next;
    logic [tlrqs_pkg::CLASS_W-1:0]     q_reg, q_next;
    logic [LW-1:0]                     x_reg, x_next;
    logic [SW-1:0]                     steps_reg, steps_next;
    logic [LW-1:0]                     head_reg [NQ];
    logic [LW-1:0]                     head_next [NQ];
    logic [LW-1:0]                     tail_reg [NQ];
    logic [LW-1:0]                     tail_next [NQ];
    logic [5:0]                        current_reg, current_next;
    logic [5:0]                        billed_reg, billed_next;
    logic                              found_reg, found_next;
    logic                              done_reg, done_next;

    // link memory
    logic [LW-1:0]                     link_mem [tlrqs_pkg::NUM_PROCS];
    logic [LW-1:0]                     rd_data_reg;
    logic                              mem_we;
    logic [IW-1:0]                     mem_waddr;
    logic [LW-1:0]                     mem_wdata;
    logic                              mem_re;
    logic [IW-1:0]                     mem_raddr;

    logic [5:0]                        hunt_cur;
    logic [5:0]                        hunt_bill;
    logic [LW-1:0]                     p_link;
    logic [LW-1:0]                     cur_head;
    logic [SW-1:0]                     steps_inc;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

    assign p_link    = {1'b0, p_reg};
    assign cur_head  = head_reg[q_reg];
    assign steps_inc = steps_reg + 1'b1;

    // highest non-empty queue, else idle
    always_comb
    begin
        hunt_cur  = cfg.idle_index;
        hunt_bill = cfg.idle_index;
        if (head_reg[tlrqs_pkg::Q_TASK] != tlrqs_pkg::NIL_LINK)
        begin
            hunt_cur  = head_reg[tlrqs_pkg::Q_TASK][IW-1:0];
            hunt_bill = billed_reg;
        end
        else if (head_reg[tlrqs_pkg::Q_SERVER] != tlrqs_pkg::NIL_LINK)
        begin
            hunt_cur  = head_reg[tlrqs_pkg::Q_SERVER][IW-1:0];
            hunt_bill = billed_reg;
        end
        else if (head_reg[tlrqs_pkg::Q_USER] != tlrqs_pkg::NIL_LINK)
        begin
            hunt_cur  = head_reg[tlrqs_pkg::Q_USER][IW-1:0];
            hunt_bill = head_reg[tlrqs_pkg::Q_USER][IW-1:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        x_next       = x_reg;
        steps_next   = steps_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        current_next = current_reg;
        billed_next  = billed_reg;
        found_next   = found_reg;
        done_next    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = p_reg;
        mem_wdata    = tlrqs_pkg::NIL_LINK;
        mem_re       = 1'b0;
        mem_raddr    = p_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    p_next     = proc_index;
                    q_next     = proc_class;
                    found_next = 1'b0;
                    state_next = ST_DISPATCH;
                end
            end

            ST_DISPATCH:
            begin
                case (op_reg)
                    tlrqs_pkg::OP_READY:
                    begin
                        if (q_reg == tlrqs_pkg::Q_USER)
                        begin
                            // push at head
                            if (cur_head == tlrqs_pkg::NIL_LINK)
                            begin
                                tail_next[q_reg] = p_link;
                            end
                            mem_we           = 1'b1;
                            mem_waddr        = p_reg;
                            mem_wdata        = cur_head;
                            head_next[q_reg] = p_link;
                            state_next       = ST_IDLE;
                            done_next        = 1'b1;
                        end
                        else
                        begin
                            if (cur_head != tlrqs_pkg::NIL_LINK)
                            begin
                                mem_we    = !tail_reg[q_reg][IW];
                                mem_waddr = tail_reg[q_reg][IW-1:0];
                                mem_wdata = p_link;
                            end
                            else
                            begin
                                head_next[q_reg] = p_link;
                                current_next     = p_reg;
                            end
                            tail_next[q_reg] = p_link;
                            state_next       = ST_RDY_NIL;
                        end
                    end

                    tlrqs_pkg::OP_UNREADY:
                    begin
                        if (cur_head == tlrqs_pkg::NIL_LINK)
                        begin
                            state_next = ST_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = cur_head[IW-1:0];
                            x_next     = cur_head;
                            steps_next = '0;
                            if (cur_head == p_link)
                            begin
                                state_next = ST_UR_HEAD;
                            end
                            else
                            begin
                                state_next = ST_UR_WALK;
                            end
                        end
                    end

                    tlrqs_pkg::OP_ROTATE:
                    begin
                        if (head_reg[tlrqs_pkg::Q_USER] == tlrqs_pkg::NIL_LINK)
                        begin
                            state_next = ST_IDLE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg[tlrqs_pkg::Q_USER][IW-1:0];
                            state_next = ST_RO_CHK;
                        end
                    end

                    default:
                    begin
                        state_next = ST_HUNT;
                    end
                endcase
            end

            ST_RDY_NIL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = p_reg;
                mem_wdata  = tlrqs_pkg::NIL_LINK;
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end

            ST_UR_HEAD:
            begin
                head_next[q_reg] = rd_data_reg;
                found_next       = 1'b1;
                if ((q_reg != tlrqs_pkg::Q_TASK) || (p_reg == current_reg))
                begin
                    state_next = ST_HUNT;
                end
                else
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end

            ST_UR_WALK:
            begin
                if (rd_data_reg == p_link)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = p_reg;
                    state_next = ST_UR_UNLINK;
                end
                else
                begin
                    x_next     = rd_data_reg;
                    steps_next = steps_inc;
                    if ((rd_data_reg == tlrqs_pkg::NIL_LINK) ||
                        (steps_inc >= SW'(tlrqs_pkg::NUM_PROCS)))
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = rd_data_reg[IW-1:0];
                    end
                end
            end

            ST_UR_UNLINK:
            begin
                mem_we    = 1'b1;
                mem_waddr = x_reg[IW-1:0];
                mem_wdata = rd_data_reg;
                if (tail_reg[q_reg] == p_link)
                begin
                    tail_next[q_reg] = x_reg;
                end
                found_next = 1'b1;
                state_next = ST_IDLE;
                done_next  = 1'b1;
            end

            ST_RO_CHK:
            begin
                if (rd_data_reg != tlrqs_pkg::NIL_LINK)
                begin
                    head_next[tlrqs_pkg::Q_USER] = rd_data_reg;
                    mem_we    = !tail_reg[tlrqs_pkg::Q_USER][IW];
                    mem_waddr = tail_reg[tlrqs_pkg::Q_USER][IW-1:0];
                    mem_wdata = head_reg[tlrqs_pkg::Q_USER];
                    tail_next[tlrqs_pkg::Q_USER] = head_reg[tlrqs_pkg::Q_USER];
                    state_next = ST_RO_FIX;
                end
                else
                begin
                    state_next = ST_HUNT;
                end
            end

            ST_RO_FIX:
            begin
                // old head is now the tail
                mem_we     = 1'b1;
                mem_waddr  = tail_reg[tlrqs_pkg::Q_USER][IW-1:0];
                mem_wdata  = tlrqs_pkg::NIL_LINK;
                state_next = ST_HUNT;
            end

            ST_HUNT:
            begin
                current_next = hunt_cur;
                billed_next  = hunt_bill;
                state_next   = ST_IDLE;
                done_next    = 1'b1;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= '{default: tlrqs_pkg::NIL_LINK};
            current_reg <= tlrqs_pkg::IDLE_INDEX_RST;
            billed_reg  <= tlrqs_pkg::IDLE_INDEX_RST;
            found_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            current_reg <= current_next;
            billed_reg  <= billed_next;
            found_reg   <= found_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        x_reg     <= x_next;
        steps_reg <= steps_next;
        tail_reg  <= tail_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign res.done    = done_reg;
    assign res.found   = found_reg;
    assign res.current = current_reg;
    assign res.billed  = billed_reg;

endmodule

`default_nettype wire

### sv/tlrqs_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tlrqs_checker
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire logic done,
    input  wire logic was_found
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not make the block busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in a row");

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        was_found |-> done)
        else $error("was_found outside a result cycle");

endmodule

bind three_level_ready_queue_scheduler_top tlrqs_checker u_tlrqs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .was_found (was_found)
);

`default_nettype wire
